### src/word_dictionary_expander_macros.svh
// Assertion macros used by the checker file of the dictionary expander.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef WORD_DICTIONARY_EXPANDER_MACROS_SVH
`define WORD_DICTIONARY_EXPANDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WDE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WDE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/wde_pkg.sv
`default_nettype none

package wde_pkg;

    // Default table geometry.
    localparam int TABLE_WORDS_DEF = 10;
    localparam int WORD_CHARS_DEF  = 9;

    // Byte values with a special meaning in the stream.
    localparam logic [7:0] CODE_LOW  = 8'd20;
    localparam logic [7:0] CODE_HIGH = 8'd29;
    localparam logic [7:0] NEWLINE   = 8'd10;
    localparam logic [7:0] ZERO_BYTE = 8'd0;

    // Result status codes.
    localparam logic [1:0] STATUS_DATA     = 2'd0;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
    localparam logic [1:0] STATUS_MISSING  = 2'd2;
    localparam logic [1:0] STATUS_DONE     = 2'd3;

    // Output byte sources.
    localparam logic [1:0] SEL_BYTE  = 2'd0;
    localparam logic [1:0] SEL_INDEX = 2'd1;
    localparam logic [1:0] SEL_ZERO  = 2'd2;
    localparam logic [1:0] SEL_RAM   = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       restart;
        logic       store_char;
        logic       store_word;
        logic       start_read;
        logic       next_read;
        logic       load_out;
        logic [1:0] out_sel;
        logic [1:0] out_status;
        logic       out_last;
    } wde_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sof;
        logic eof;
        logic is_newline;
        logic is_zero;
        logic is_code;
        logic code_missing;
        logic char_empty;
        logic char_full;
        logic table_last;
        logic last_char;
        logic out_free;
    } wde_sts_t;

endpackage

`default_nettype wire

### src/wde_in_if.sv
`default_nettype none

// Compressed byte channel.
interface wde_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_file;
    logic       end_of_file;

    modport source (output valid, output data_byte, output start_of_file,
                    output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input start_of_file,
                    input end_of_file, output ready);
endinterface

`default_nettype wire

### src/wde_out_if.sv
`default_nettype none

// Expanded result channel.
interface wde_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output out_byte, output status, output last,
                    input ready);
    modport sink   (input valid, input out_byte, input status, input last,
                    output ready);
endinterface

`default_nettype wire

### src/wde_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module wde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/wde_datapath.sv
`default_nettype none

// Word table, header counters, expansion pointers and the output register.
module wde_datapath #(
    parameter int TABLE_WORDS = wde_pkg::TABLE_WORDS_DEF,
    parameter int WORD_CHARS  = wde_pkg::WORD_CHARS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  wde_pkg::wde_cmd_t cmd,
    output wde_pkg::wde_sts_t sts,
    input  logic [7:0]        data_byte,
    input  logic              start_of_file,
    input  logic              end_of_file,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [7:0]        out_byte,
    output logic [1:0]        out_status,
    output logic              out_last
);

    localparam int DEPTH  = TABLE_WORDS * WORD_CHARS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_WORDS + 1);
    localparam int CHAR_W = $clog2(WORD_CHARS + 1);
    localparam int IDX_W  = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1;

    logic [CNT_W-1:0]  word_count_reg, word_count_next, wc_eff;
    logic [CHAR_W-1:0] char_index_reg, char_index_next, ci_eff;
    logic [ADDR_W-1:0] wr_base_reg, wr_base_next, base_eff;
    logic [CHAR_W-1:0] len_mem [TABLE_WORDS];
    logic [CHAR_W-1:0] len_reg, len_next;
    logic [CHAR_W-1:0] emit_cnt_reg, emit_cnt_next;
    logic [ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic [7:0]        code_off;
    logic [3:0]        code_idx;
    logic [IDX_W-1:0]  word_sel;
    logic [ADDR_W-1:0] word_base;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic              ram_re;
    logic [7:0]        ram_rdata;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic [1:0]        out_status_reg;
    logic              out_last_reg;

    // Counter values as seen by this beat; a start mark clears them.
    assign wc_eff   = start_of_file ? '0 : word_count_reg;
    assign ci_eff   = start_of_file ? '0 : char_index_reg;
    assign base_eff = start_of_file ? '0 : wr_base_reg;

    // Code byte decode and the table position of the named word.
    assign code_off  = data_byte - wde_pkg::CODE_LOW;
    assign code_idx  = code_off[3:0];
    assign word_sel  = code_idx[IDX_W-1:0];
    assign word_base = ADDR_W'(word_sel * WORD_CHARS);

    // Status toward the controller.
    always_comb
    begin
        sts.sof          = start_of_file;
        sts.eof          = end_of_file;
        sts.is_newline   = (data_byte == wde_pkg::NEWLINE);
        sts.is_zero      = (data_byte == wde_pkg::ZERO_BYTE);
        sts.is_code      = (data_byte >= wde_pkg::CODE_LOW) &&
                           (data_byte <= wde_pkg::CODE_HIGH);
        sts.code_missing = (5'(code_idx) >= 5'(wc_eff));
        sts.char_empty   = (ci_eff == '0);
        sts.char_full    = (ci_eff == CHAR_W'(WORD_CHARS));
        sts.table_last   = (wc_eff == CNT_W'(TABLE_WORDS - 1));
        sts.last_char    = ((emit_cnt_reg + CHAR_W'(1)) == len_reg);
        sts.out_free     = !out_valid_reg || out_ready;
    end

    // Header counters.
    always_comb
    begin
        word_count_next = cmd.restart ? '0 : word_count_reg;
        char_index_next = cmd.restart ? '0 : char_index_reg;
        wr_base_next    = cmd.restart ? '0 : wr_base_reg;
        if (cmd.store_char)
        begin
            char_index_next = ci_eff + CHAR_W'(1);
        end
        else if (cmd.store_word)
        begin
            word_count_next = wc_eff + CNT_W'(1);
            char_index_next = '0;
            wr_base_next    = base_eff + ADDR_W'(WORD_CHARS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg <= '0;
            char_index_reg <= '0;
            wr_base_reg    <= '0;
        end
        else
        begin
            word_count_reg <= word_count_next;
            char_index_reg <= char_index_next;
            wr_base_reg    <= wr_base_next;
        end
    end

    // Stored word lengths; an entry is read only after its word is complete.
    always_ff @(posedge clk)
    begin
        if (cmd.store_word)
        begin
            len_mem[wc_eff[IDX_W-1:0]] <= ci_eff;
        end
    end

    // Expansion pointers: the held read address, the word length and the
    // number of characters already sent.
    always_comb
    begin
        len_next      = len_reg;
        rd_addr_next  = rd_addr_reg;
        emit_cnt_next = emit_cnt_reg;
        if (cmd.start_read)
        begin
            len_next      = len_mem[word_sel];
            rd_addr_next  = word_base;
            emit_cnt_next = '0;
        end
        else
        begin
            if (cmd.next_read)
            begin
                rd_addr_next = rd_addr_reg + ADDR_W'(1);
            end
            if (cmd.load_out && (cmd.out_sel == wde_pkg::SEL_RAM))
            begin
                emit_cnt_next = emit_cnt_reg + CHAR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_cnt_reg <= '0;
        end
        else
        begin
            emit_cnt_reg <= emit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg     <= len_next;
        rd_addr_reg <= rd_addr_next;
    end

    // Character table.
    assign ram_waddr = base_eff + ADDR_W'(ci_eff);
    assign ram_re    = cmd.start_read || cmd.next_read;
    assign ram_raddr = cmd.start_read ? word_base : (rd_addr_reg + ADDR_W'(1));

    wde_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_char_ram (
        .clk   (clk),
        .we    (cmd.store_char),
        .waddr (ram_waddr),
        .wdata (data_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output byte source.
    always_comb
    begin
        unique case (cmd.out_sel)
            wde_pkg::SEL_BYTE:  out_byte_next = data_byte;
            wde_pkg::SEL_INDEX: out_byte_next = code_off;
            wde_pkg::SEL_ZERO:  out_byte_next = wde_pkg::ZERO_BYTE;
            wde_pkg::SEL_RAM:   out_byte_next = ram_rdata;
        endcase
    end

    // Output register; a new result may load in the cycle the old one leaves.
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_byte_reg   <= out_byte_next;
            out_status_reg <= cmd.out_status;
            out_last_reg   <= cmd.out_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule

`default_nettype wire

### src/wde_ctrl.sv
`default_nettype none

// Stream phase tracking and the expansion sequencer.
module wde_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  wde_pkg::wde_sts_t sts,
    output wde_pkg::wde_cmd_t cmd
);

    localparam logic       ST_ACCEPT = 1'b0;
    localparam logic       ST_EXPAND = 1'b1;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_BODY   = 2'd1;
    localparam logic [1:0] PH_HALT   = 2'd2;

    logic       state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic [1:0] phase_eff;

    // A start mark puts this beat into header reading.
    assign phase_eff = sts.sof ? PH_HEADER : phase_reg;

    // Beat decode and expansion steps.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        phase_next = phase_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_ACCEPT:
            begin
                in_ready = sts.out_free;
                if (in_valid && sts.out_free)
                begin
                    cmd.restart = sts.sof;
                    phase_next  = phase_eff;
                    unique case (phase_eff)
                        PH_HEADER:
                        begin
                            priority if (sts.eof)
                            begin
                                cmd.load_out   = 1'b1;
                                cmd.out_sel    = wde_pkg::SEL_ZERO;
                                cmd.out_status = wde_pkg::STATUS_DONE;
                                cmd.out_last   = 1'b1;
                                phase_next     = PH_HALT;
                            end
                            else if (sts.is_newline)
                            begin
                                if (sts.char_empty)
                                begin
                                    phase_next = PH_BODY;
                                end
                                else
                                begin
                                    cmd.store_word = 1'b1;
                                    if (sts.table_last)
                                    begin
                                        phase_next = PH_BODY;
                                    end
                                end
                            end
                            else if (!sts.char_full)
                            begin
                                cmd.store_char = 1'b1;
                            end
                            else
                            begin
                                cmd.load_out   = 1'b1;
                                cmd.out_sel    = wde_pkg::SEL_ZERO;
                                cmd.out_status = wde_pkg::STATUS_TOO_LONG;
                                cmd.out_last   = 1'b1;
                                phase_next     = PH_HALT;
                            end
                        end
                        PH_BODY:
                        begin
                            priority if (sts.eof || sts.is_zero)
                            begin
                                cmd.load_out   = 1'b1;
                                cmd.out_sel    = wde_pkg::SEL_ZERO;
                                cmd.out_status = wde_pkg::STATUS_DONE;
                                cmd.out_last   = 1'b1;
                                phase_next     = PH_HALT;
                            end
                            else if (sts.is_code && sts.code_missing)
                            begin
                                cmd.load_out   = 1'b1;
                                cmd.out_sel    = wde_pkg::SEL_INDEX;
                                cmd.out_status = wde_pkg::STATUS_MISSING;
                                cmd.out_last   = 1'b1;
                            end
                            else if (sts.is_code)
                            begin
                                cmd.start_read = 1'b1;
                                state_next     = ST_EXPAND;
                            end
                            else
                            begin
                                cmd.load_out   = 1'b1;
                                cmd.out_sel    = wde_pkg::SEL_BYTE;
                                cmd.out_status = wde_pkg::STATUS_DATA;
                                cmd.out_last   = 1'b1;
                            end
                        end
                        default:
                        begin
                            // Halted: beats are consumed without a result.
                        end
                    endcase
                end
            end
            ST_EXPAND:
            begin
                // The read data holds the next character; send it when the
                // output register frees up and, unless it is the last, fetch the one after it.
                if (sts.out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.out_sel    = wde_pkg::SEL_RAM;
                    cmd.out_status = wde_pkg::STATUS_DATA;
                    cmd.out_last   = sts.last_char;
                    if (sts.last_char)
                    begin
                        state_next = ST_ACCEPT;
                    end
                    else
                    begin
                        cmd.next_read = 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCEPT;
            phase_reg <= PH_HEADER;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

### src/word_dictionary_expander.sv
`default_nettype none

// Channel      Direction  Beat contents
// compressed   in         data_byte, start_of_file, end_of_file
// expanded     out        out_byte, status, last
//
// Header, pass-through and status beats are handled as the input beat is taken.
// A code byte naming a stored word holds off input until its last character is loaded
// for output; the character RAM fetches the first, and each then goes out as the next is read.
// The character RAM read port gives one character per cycle while output flows.
// Reset clears the counters, phase and output valid; the tables need no clear.
// A stalled output holds its result and blocks new input beats.

module word_dictionary_expander #(
    parameter int TABLE_WORDS = wde_pkg::TABLE_WORDS_DEF,
    parameter int WORD_CHARS  = wde_pkg::WORD_CHARS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    wde_in_if.sink   compressed,
    wde_out_if.source expanded
);

    wde_pkg::wde_cmd_t cmd;
    wde_pkg::wde_sts_t sts;
    logic              in_ready;

    // Controller.
    wde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (compressed.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    assign compressed.ready = in_ready;

    // Datapath.
    wde_datapath #(
        .TABLE_WORDS (TABLE_WORDS),
        .WORD_CHARS  (WORD_CHARS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .data_byte     (compressed.data_byte),
        .start_of_file (compressed.start_of_file),
        .end_of_file   (compressed.end_of_file),
        .out_ready     (expanded.ready),
        .out_valid     (expanded.valid),
        .out_byte      (expanded.out_byte),
        .out_status    (expanded.status),
        .out_last      (expanded.last)
    );

endmodule

`default_nettype wire

### src/wde_checker.sv
`default_nettype none

`include "word_dictionary_expander_macros.svh"

// Port-level checks on the expanded result channel.
module wde_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic [1:0] out_status,
    input logic       out_last
);

    // A stalled beat keeps its contents.
    `WDE_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_status) && $stable(out_last), "stalled result changed")

    // Any status beat is the last result of its input beat.
    `WDE_ASSERT_SAME(a_status_last, out_valid && (out_status != wde_pkg::STATUS_DATA), out_last, "status beat without last")

    // Done and too-long beats carry a zero byte.
    `WDE_ASSERT_SAME(a_zero_byte, out_valid && ((out_status == wde_pkg::STATUS_DONE) || (out_status == wde_pkg::STATUS_TOO_LONG)), out_byte == 8'd0, "nonzero byte on a done or too-long beat")

    // A missing-word beat carries a word index.
    `WDE_ASSERT_SAME(a_missing_index, out_valid && (out_status == wde_pkg::STATUS_MISSING), out_byte <= 8'd9, "missing-word index out of range")

endmodule

bind word_dictionary_expander wde_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (expanded.valid),
    .out_ready  (expanded.ready),
    .out_byte   (expanded.out_byte),
    .out_status (expanded.status),
    .out_last   (expanded.last)
);

`default_nettype wire

### bench/tb_top.sv
`default_nettype none

module tb_top;

    import wde_pkg::*;

    localparam int TABLE_WORDS  = TABLE_WORDS_DEF;
    localparam int WORD_CHARS   = WORD_CHARS_DEF;
    localparam int ITEM_TARGET  = 120;
    localparam int MAX_WAIT     = 13;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 30;

    // Decoder phase as the predictor tracks it.
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY,
        PH_HALTED
    } dec_phase_t;

    // How the expectation of a stimulus row is formed.
    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_QUIET,
        CHK_ONE
    } check_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [7:0] data;
        logic       sof;
        logic       eof;
        check_t     chk;
        logic [7:0] fix_byte;
        logic [1:0] fix_status;
    } stim_row_t;

    // Directed rows: fixed expectations are typed where they are obvious.
    localparam stim_row_t DIRECTED [25] = '{
        '{8'h68,            1'b1, 1'b0, CHK_QUIET,   ZERO_BYTE, STATUS_DATA},
        '{ZERO_BYTE,        1'b0, 1'b0, CHK_QUIET,   ZERO_BYTE, STATUS_DATA},
        '{8'hFF,            1'b0, 1'b0, CHK_QUIET,   ZERO_BYTE, STATUS_DATA},
        '{NEWLINE,          1'b0, 1'b0, CHK_QUIET,   ZERO_BYTE, STATUS_DATA},
        '{NEWLINE,          1'b0, 1'b0, CHK_QUIET,   ZERO_BYTE, STATUS_DATA},
        '{CODE_LOW,         1'b0, 1'b0, CHK_PREDICT, ZERO_BYTE, STATUS_DATA},
        '{CODE_LOW + 8'd1,  1'b0, 1'b0, CHK_ONE,     8'd1,      STATUS_MISSING},
        '{CODE_HIGH,        1'b0, 1'b0, CHK_ONE,     8'd9,      STATUS_MISSING},
        '{CODE_LOW - 8'd1,  1'b0, 1'b0, CHK_ONE,     8'd19,     STATUS_DATA},
        '{8'hFF,            1'b0, 1'b0, CHK_ONE,     8'hFF,     STATUS_DATA},
        '{NEWLINE,          1'b0, 1'b0, CHK_ONE,     NEWLINE,   STATUS_DATA},
        '{ZERO_BYTE,        1'b0, 1'b0, CHK_ONE,     ZERO_BYTE, STATUS_DONE},
        '{8'h41,            1'b0, 1'b0, CHK_QUIET,   ZERO_BYTE, STATUS_DATA},
        '{8'h5A,            1'b0, 1'b1, CHK_QUIET,   ZERO_BYTE, STATUS_DATA},
        '{8'hA5,            1'b1, 1'b1, CHK_ONE,     ZERO_BYTE, STATUS_DONE},
        '{8'h61,            1'b1, 1'b0, CHK_QUIET,   ZERO_BYTE, STATUS_DATA},
        '{8'h62,            1'b0, 1'b0, CHK_QUIET,   ZERO_BYTE, STATUS_DATA},
        '{8'h63,            1'b0, 1'b0, CHK_QUIET,   ZERO_BYTE, STATUS_DATA},
        '{8'h64,            1'b0, 1'b0, CHK_QUIET,   ZERO_BYTE, STATUS_DATA},
        '{8'h65,            1'b0, 1'b0, CHK_QUIET,   ZERO_BYTE, STATUS_DATA},
        '{8'h66,            1'b0, 1'b0, CHK_QUIET,   ZERO_BYTE, STATUS_DATA},
        '{8'h67,            1'b0, 1'b0, CHK_QUIET,   ZERO_BYTE, STATUS_DATA},
        '{8'h68,            1'b0, 1'b0, CHK_QUIET,   ZERO_BYTE, STATUS_DATA},
        '{8'h69,            1'b0, 1'b0, CHK_QUIET,   ZERO_BYTE, STATUS_DATA},
        '{8'h7A,            1'b0, 1'b0, CHK_ONE,     ZERO_BYTE, STATUS_TOO_LONG}
    };

    logic clk;
    logic rst_n;

    wde_in_if  compressed_ch ();
    wde_out_if expanded_ch ();

    word_dictionary_expander i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .compressed (compressed_ch),
        .expanded   (expanded_ch)
    );

    // Predictor state.
    logic [7:0] word_store [TABLE_WORDS * WORD_CHARS];
    logic [3:0] word_len [TABLE_WORDS];
    logic [3:0] word_total;
    logic [3:0] fill_slot;
    logic [3:0] fill_char;
    dec_phase_t dec_phase;

    result_t step_results [$];
    result_t pending_results [$];

    // Expectation mode of the beat currently on the input channel.
    check_t     cur_chk;
    logic [7:0] cur_fix_byte;
    logic [1:0] cur_fix_status;

    bit no_idle;
    int items_sent;
    int streams_run;
    int beats_in;
    int beats_out;
    int mismatches;
    int idle_cycles;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    function automatic void add_result(input logic [7:0] b, input logic [1:0] st,
                                       input logic lst);
        result_t r;
        r.out_byte = b;
        r.status   = st;
        r.last     = lst;
        step_results.push_back(r);
    endfunction

    // Compute the results one input beat causes and advance the decoder state.
    function automatic void expand_byte(input logic [7:0] b, input logic sof,
                                        input logic eof);
        logic [7:0] idx;
        int         len;
        step_results.delete();
        if (sof)
        begin
            word_total = '0;
            fill_slot  = '0;
            fill_char  = '0;
            dec_phase  = PH_HEADER;
        end
        case (dec_phase)
            PH_HEADER:
            begin
                if (eof)
                begin
                    dec_phase = PH_HALTED;
                    add_result(ZERO_BYTE, STATUS_DONE, 1'b1);
                end
                else if (b == NEWLINE)
                begin
                    if (fill_char == 0)
                    begin
                        dec_phase = PH_BODY;
                    end
                    else
                    begin
                        word_len[fill_slot] = fill_char;
                        fill_slot  = fill_slot + 1'b1;
                        word_total = word_total + 1'b1;
                        fill_char  = '0;
                        if (word_total >= TABLE_WORDS)
                        begin
                            dec_phase = PH_BODY;
                        end
                    end
                end
                else if (fill_char < WORD_CHARS && fill_slot < TABLE_WORDS)
                begin
                    word_store[fill_slot * WORD_CHARS + fill_char] = b;
                    fill_char = fill_char + 1'b1;
                end
                else
                begin
                    dec_phase = PH_HALTED;
                    add_result(ZERO_BYTE, STATUS_TOO_LONG, 1'b1);
                end
            end
            PH_BODY:
            begin
                if (eof || b == ZERO_BYTE)
                begin
                    dec_phase = PH_HALTED;
                    add_result(ZERO_BYTE, STATUS_DONE, 1'b1);
                end
                else if (b >= CODE_LOW && b <= CODE_HIGH)
                begin
                    idx = b - CODE_LOW;
                    if (idx >= word_total)
                    begin
                        add_result(idx, STATUS_MISSING, 1'b1);
                    end
                    else
                    begin
                        len = word_len[idx];
                        for (int i = 0; i < len; i++)
                        begin
                            add_result(word_store[idx * WORD_CHARS + i], STATUS_DATA,
                                       i == len - 1);
                        end
                    end
                end
                else
                begin
                    add_result(b, STATUS_DATA, 1'b1);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Wait drawn per beat; zero throughout a stretch without idling.
    function automatic int draw_wait();
        if (no_idle)
        begin
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Drive one input beat and hold it until the block takes it.
    task automatic send_item(input logic [7:0] data, input logic sof, input logic eof,
                             input check_t chk, input logic [7:0] fix_byte,
                             input logic [1:0] fix_status, input bit counted);
        int gap;
        gap = draw_wait();
        @(negedge clk);
        if (gap > 0)
        begin
            compressed_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        compressed_ch.data_byte     = data;
        compressed_ch.start_of_file = sof;
        compressed_ch.end_of_file   = eof;
        cur_chk                     = chk;
        cur_fix_byte                = fix_byte;
        cur_fix_status              = fix_status;
        compressed_ch.valid         = 1'b1;
        do
            @(posedge clk);
        while (!compressed_ch.ready);
        if (counted)
        begin
            items_sent++;
        end
    endtask

    task automatic send_rand(input logic [7:0] data, input logic sof, input logic eof);
        send_item(data, sof, eof, CHK_PREDICT, ZERO_BYTE, STATUS_DATA, 1'b1);
    endtask

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do
            c = 8'($urandom);
        while (c == NEWLINE);
        return c;
    endfunction

    // One stream: a header of random words, then a body of codes and plain bytes.
    // Some streams break off in the header or restart in the middle of the body.
    task automatic run_stream();
        int         kind;
        int         words;
        int         len;
        int         body_len;
        int         bad_word;
        logic       sof;
        logic [7:0] b;
        sof   = 1'b1;
        kind  = $urandom_range(0, 9);
        words = ($urandom_range(0, 7) == 0) ? TABLE_WORDS : $urandom_range(0, 3);
        bad_word = $urandom_range(0, words);

        for (int w = 0; w <= words; w++)
        begin
            if (w == words && kind > 1)
            begin
                break;
            end
            len = ($urandom_range(0, 3) == 0) ? WORD_CHARS : $urandom_range(1, 3);
            if (kind == 0 && w == bad_word)
            begin
                // End of file in the header, possibly inside a word.
                len = $urandom_range(0, WORD_CHARS);
                for (int c = 0; c < len; c++)
                begin
                    send_rand(word_char(), sof, 1'b0);
                    sof = 1'b0;
                end
                send_rand(8'($urandom), sof, 1'b1);
                break;
            end
            if (kind == 1 && w == bad_word)
            begin
                // One character more than a word can hold.
                for (int c = 0; c <= WORD_CHARS; c++)
                begin
                    send_rand(word_char(), sof, 1'b0);
                    sof = 1'b0;
                end
                break;
            end
            if (w == words)
            begin
                break;
            end
            for (int c = 0; c < len; c++)
            begin
                send_rand(word_char(), sof, 1'b0);
                sof = 1'b0;
            end
            send_rand(NEWLINE, sof, 1'b0);
            sof = 1'b0;
        end

        if (kind <= 1)
        begin
            // The block is halted now; these beats are ignored.
            repeat ($urandom_range(1, 3))
            begin
                send_item(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), CHK_PREDICT,
                          ZERO_BYTE, STATUS_DATA, 1'b0);
            end
            return;
        end

        // An empty line ends an unfilled header; after a full header it may be a body byte.
        if (words < TABLE_WORDS || $urandom_range(0, 1) == 0)
        begin
            send_rand(NEWLINE, sof, 1'b0);
            sof = 1'b0;
        end

        body_len = $urandom_range(3, 12);
        for (int i = 0; i < body_len; i++)
        begin
            if ($urandom_range(0, 9) < 5)
            begin
                b = CODE_LOW + 8'($urandom_range(0, 9));
            end
            else
            begin
                do
                    b = 8'($urandom);
                while (b == ZERO_BYTE);
            end
            send_rand(b, sof, 1'b0);
            sof = 1'b0;
        end

        // Most streams end cleanly; a restart mark cuts the others short.
        if (kind != 2)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                send_rand(ZERO_BYTE, 1'b0, 1'b0);
            end
            else
            begin
                send_rand(8'($urandom), 1'b0, 1'b1);
            end
        end
    endtask

    // Result sink: holds ready low for the wait that draw_wait gives before each beat.
    initial
    begin
        int gap;
        expanded_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = draw_wait();
            @(negedge clk);
            if (gap > 0)
            begin
                expanded_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            expanded_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (!expanded_ch.valid);
        end
    end

    // Check result beats in order, then predict from the accepted input beat.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            idle_cycles++;
            if (expanded_ch.valid && expanded_ch.ready)
            begin
                idle_cycles = 0;
                beats_out++;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %h/%0d/%0b",
                             $time, expanded_ch.out_byte, expanded_ch.status,
                             expanded_ch.last);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (expanded_ch.out_byte !== want.out_byte)
                    begin
                        $display("%0t: out_byte expected %h, actual %h", $time,
                                 want.out_byte, expanded_ch.out_byte);
                        mismatches++;
                    end
                    if (expanded_ch.status !== want.status)
                    begin
                        $display("%0t: status expected %0d, actual %0d", $time,
                                 want.status, expanded_ch.status);
                        mismatches++;
                    end
                    if (expanded_ch.last !== want.last)
                    begin
                        $display("%0t: last expected %0b, actual %0b", $time,
                                 want.last, expanded_ch.last);
                        mismatches++;
                    end
                end
            end
            if (compressed_ch.valid && compressed_ch.ready)
            begin
                idle_cycles = 0;
                beats_in++;
                expand_byte(compressed_ch.data_byte, compressed_ch.start_of_file,
                            compressed_ch.end_of_file);
                case (cur_chk)
                    CHK_PREDICT:
                    begin
                        foreach (step_results[i])
                        begin
                            pending_results.push_back(step_results[i]);
                        end
                    end
                    CHK_ONE:
                    begin
                        want.out_byte = cur_fix_byte;
                        want.status   = cur_fix_status;
                        want.last     = 1'b1;
                        pending_results.push_back(want);
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                         $time, IDLE_LIMIT, pending_results.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Stimulus: directed rows, random streams, then drain and report.
    initial
    begin
        compressed_ch.valid         = 1'b0;
        compressed_ch.data_byte     = '0;
        compressed_ch.start_of_file = 1'b0;
        compressed_ch.end_of_file   = 1'b0;
        cur_chk        = CHK_QUIET;
        cur_fix_byte   = ZERO_BYTE;
        cur_fix_status = STATUS_DATA;
        no_idle     = 1'b0;
        items_sent  = 0;
        streams_run = 0;
        beats_in    = 0;
        beats_out   = 0;
        mismatches  = 0;
        idle_cycles = 0;

        // Decoder state after reset; table contents are never read unwritten.
        word_total = '0;
        fill_slot  = '0;
        fill_char  = '0;
        dec_phase  = PH_HEADER;
        foreach (word_store[i])
        begin
            word_store[i] = '0;
        end
        foreach (word_len[i])
        begin
            word_len[i] = '0;
        end

        @(posedge rst_n);

        foreach (DIRECTED[i])
        begin
            send_item(DIRECTED[i].data, DIRECTED[i].sof, DIRECTED[i].eof, DIRECTED[i].chk,
                      DIRECTED[i].fix_byte, DIRECTED[i].fix_status, 1'b1);
        end

        // Random streams fill up the rest of the item budget.
        while (items_sent < ITEM_TARGET)
        begin
            no_idle = (streams_run % 3 == 2);
            run_stream();
            streams_run++;
        end
        no_idle = 1'b0;

        @(negedge clk);
        compressed_ch.valid = 1'b0;

        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d directed rows and %0d random streams (%0d input beats in all).",
                 $size(DIRECTED), streams_run, beats_in);
        $display("Checked %0d result beats; %0d field mismatches.", beats_out, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
